@@ hdl/dry_wet_mix_distortion_meter_top_macros.svh @@
// assertion macros used by the checker file
`ifndef DRY_WET_MIX_DISTORTION_METER_TOP_MACROS_SVH
`define DRY_WET_MIX_DISTORTION_METER_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define DWM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define DWM_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/dwm_pkg.sv @@
// types, constants and helpers for the dry/wet mixer and distortion meter
`timescale 1ns / 1ps

package dwm_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int MIX_W      = 16;
    localparam int HEAT_W     = 17;
    localparam int ACC_W      = 60;
    localparam int FLOOR_W    = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int MUL_W      = 33;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENERGY_FLOOR  = 2'd1;

    // reset values of the configuration registers
    localparam logic [1:0]         CHANNEL_COUNT_RST = 2'd2;
    localparam logic [FLOOR_W-1:0] ENERGY_FLOOR_RST  = 40'd70369;

    // fully wet mix weight and unity heat
    localparam logic [MIX_W-1:0]  MIX_ONE  = 16'd32768;
    localparam logic [HEAT_W-1:0] HEAT_ONE = 17'd65536;

    // bit-serial divide lengths: square over sum, residual scaled by 2^32
    localparam logic [6:0] DIV1_STEPS = 7'd120;
    localparam logic [6:0] DIV2_STEPS = 7'd92;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] wet_left;
        logic signed [SAMPLE_W-1:0] wet_right;
        logic signed [SAMPLE_W-1:0] dry_left;
        logic signed [SAMPLE_W-1:0] dry_right;
        logic        [MIX_W-1:0]    mix_weight;
        logic                       block_end;
    } dwm_in_word_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_left;
        logic signed [SAMPLE_W-1:0] out_right;
        logic        [HEAT_W-1:0]   heat;
        logic                       heat_valid;
    } dwm_out_word_t;

    // sign extend a sample to a multiplier operand
    function automatic logic signed [MUL_W-1:0] sext_sample(
        input logic signed [SAMPLE_W-1:0] s
    );
        return {{(MUL_W-SAMPLE_W){s[SAMPLE_W-1]}}, s};
    endfunction

endpackage

@@ hdl/dry_wet_mix_distortion_meter_top.sv @@
// dry/wet mixer with least-squares distortion meter on the left channel
`timescale 1ns / 1ps
//
// channel | handshake                 | word
// --------+---------------------------+----------------------------------------
// input   | in_valid / in_stall       | in_word: wet, dry, mix weight, end flag
// output  | out_valid / out_stall     | out_word: mixed left/right, heat, flag
// config  | cfg_wr_en, cfg_index      | cfg_data: channel count, energy floor
//
// a word is accepted in the idle state, then runs eight steps through one shared 33x33
// multiplier, then the finish state loads the output register once it is free; a block-end
// word also computes heat (zero when an energy is at or below the floor): a check, a
// partial-product square, the one-bit-a-cycle divider, the residual, the divider again
// and the square root
// in_stall is high from acceptance until the result sits in the output register
// a waiting result in the output register does not block acceptance of the next word
// rst_n resets control, accumulators and configuration at once; no clearing pass

module dry_wet_mix_distortion_meter_top
    import dwm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  dwm_in_word_t          in_word,
    output logic                  out_valid,
    input  logic                  out_stall,
    output dwm_out_word_t         out_word,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [FLOOR_W-1:0]    cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MIX,
        ST_CHECK,
        ST_SQUARE,
        ST_DIV1,
        ST_RESID,
        ST_DIV2,
        ST_ROOT,
        ST_FINISH
    } state_t;

    localparam logic [32:0] ROOT_BIT_INIT = 33'h1_0000_0000;
    localparam logic [32:0] ROOT_LIMIT    = 33'h1_0000_0000;

    // control registers
    state_t               state_reg, state_next;
    logic [2:0]           step_reg, step_next;
    logic [6:0]           iter_reg, iter_next;
    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           channel_count_reg, channel_count_next;
    logic [FLOOR_W-1:0]   energy_floor_reg, energy_floor_next;
    logic [ACC_W-1:0]     sum_in_reg, sum_in_next;
    logic [ACC_W-1:0]     sum_out_reg, sum_out_next;
    logic [ACC_W-1:0]     sum_cross_reg, sum_cross_next;

    // datapath registers
    dwm_in_word_t         item_reg, item_next;
    dwm_out_word_t        out_word_reg, out_word_next;
    logic signed [65:0]   prod_reg;
    logic signed [41:0]   t_reg, t_next;
    logic signed [SAMPLE_W-1:0] ol_reg, ol_next;
    logic signed [SAMPLE_W-1:0] or_reg, or_next;
    logic [119:0]         num_reg, num_next;
    logic [ACC_W-1:0]     rem_reg, rem_next;
    logic [ACC_W-1:0]     quo_reg, quo_next;
    logic                 over_reg, over_next;
    logic [32:0]          root_n_reg, root_n_next;
    logic [32:0]          root_res_reg, root_res_next;
    logic [32:0]          root_bit_reg, root_bit_next;
    logic [HEAT_W-1:0]    heat_reg, heat_next;

    // combinational helpers
    logic [MIX_W-1:0]         m_sat;
    logic [MIX_W-1:0]         m_inv;
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [41:0]       tsum;
    logic signed [SAMPLE_W-1:0] mix_res;
    logic [ACC_W:0]           acc_sum;
    logic [ACC_W:0]           cross_sum;
    logic [ACC_W-1:0]         ax;
    logic [ACC_W-1:0]         div_d;
    logic [ACC_W:0]           rem_sh;
    logic [ACC_W:0]           div_diff;
    logic                     div_ge;
    logic [ACC_W-1:0]         quo_shift;
    logic [ACC_W-1:0]         residual;
    logic [33:0]              root_sum;
    logic                     root_ge;
    logic [32:0]              root_res_upd;
    logic [32:0]              root_n_clamp;

    // saturate a shifted mix sum to the sample range
    function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [26:0] v);
        if (v > 27'sd8388607)
        begin
            return 24'h7FFFFF;
        end
        else if (v < -27'sd8388608)
        begin
            return 24'h800000;
        end
        return v[SAMPLE_W-1:0];
    endfunction

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // clamp mix weight and form its complement
    assign m_sat = (item_reg.mix_weight > MIX_ONE) ? MIX_ONE : item_reg.mix_weight;
    assign m_inv = MIX_ONE - m_sat;

    // magnitude of the cross sum, split into 30-bit halves for squaring
    assign ax = sum_cross_reg[ACC_W-1] ? (~sum_cross_reg + 60'd1) : sum_cross_reg;

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MIX:
            begin
                case (step_reg)
                    3'd0:
                    begin
                        mul_a = $signed({17'b0, m_sat});
                        mul_b = sext_sample(item_reg.wet_left);
                    end
                    3'd1:
                    begin
                        mul_a = $signed({17'b0, m_inv});
                        mul_b = sext_sample(item_reg.dry_left);
                    end
                    3'd2:
                    begin
                        mul_a = $signed({17'b0, m_sat});
                        mul_b = sext_sample(item_reg.wet_right);
                    end
                    3'd3:
                    begin
                        mul_a = $signed({17'b0, m_inv});
                        mul_b = sext_sample(item_reg.dry_right);
                    end
                    3'd4:
                    begin
                        mul_a = sext_sample(item_reg.dry_left);
                        mul_b = sext_sample(item_reg.dry_left);
                    end
                    3'd5:
                    begin
                        mul_a = sext_sample(ol_reg);
                        mul_b = sext_sample(ol_reg);
                    end
                    3'd6:
                    begin
                        mul_a = sext_sample(item_reg.dry_left);
                        mul_b = sext_sample(ol_reg);
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            ST_SQUARE:
            begin
                case (step_reg)
                    3'd0:
                    begin
                        mul_a = $signed({3'b0, ax[29:0]});
                        mul_b = $signed({3'b0, ax[29:0]});
                    end
                    3'd1:
                    begin
                        mul_a = $signed({3'b0, ax[29:0]});
                        mul_b = $signed({3'b0, ax[59:30]});
                    end
                    3'd2:
                    begin
                        mul_a = $signed({3'b0, ax[59:30]});
                        mul_b = $signed({3'b0, ax[59:30]});
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // mix rounding and saturation
    assign tsum    = t_reg + $signed(prod_reg[41:0]) + 42'sd16384;
    assign mix_res = sat_sample(tsum[41:15]);

    // saturating accumulator adders
    assign acc_sum   = (step_reg == 3'd5) ? ({1'b0, sum_in_reg} + {14'b0, prod_reg[46:0]})
                                          : ({1'b0, sum_out_reg} + {14'b0, prod_reg[46:0]});
    assign cross_sum = {sum_cross_reg[ACC_W-1], sum_cross_reg} + prod_reg[60:0];

    // shared restoring divider step
    assign div_d     = (state_reg == ST_DIV1) ? sum_in_reg : sum_out_reg;
    assign rem_sh    = {rem_reg, num_reg[119]};
    assign div_ge    = (rem_sh >= {1'b0, div_d});
    assign div_diff  = rem_sh - {1'b0, div_d};
    assign quo_shift = {quo_reg[ACC_W-2:0], div_ge};

    // residual energy after removing the best-fit dry component
    assign residual = (over_reg || (quo_reg >= sum_out_reg)) ? '0 : (sum_out_reg - quo_reg);

    // clamp of the scaled ratio before the root
    assign root_n_clamp = ((over_reg || quo_reg[ACC_W-2]) || (quo_shift > {27'b0, ROOT_LIMIT}))
                          ? ROOT_LIMIT : quo_shift[32:0];

    // square root step
    assign root_sum     = {1'b0, root_res_reg} + {1'b0, root_bit_reg};
    assign root_ge      = ({1'b0, root_n_reg} >= root_sum);
    assign root_res_upd = root_ge ? ((root_res_reg >> 1) + root_bit_reg) : (root_res_reg >> 1);

    // sequencer and next-state logic
    always_comb
    begin
        state_next         = state_reg;
        step_next          = step_reg;
        iter_next          = iter_reg;
        out_valid_next     = out_valid_reg;
        channel_count_next = channel_count_reg;
        energy_floor_next  = energy_floor_reg;
        sum_in_next        = sum_in_reg;
        sum_out_next       = sum_out_reg;
        sum_cross_next     = sum_cross_reg;
        item_next          = item_reg;
        out_word_next      = out_word_reg;
        t_next             = t_reg;
        ol_next            = ol_reg;
        or_next            = or_reg;
        num_next           = num_reg;
        rem_next           = rem_reg;
        quo_next           = quo_reg;
        over_next          = over_reg;
        root_n_next        = root_n_reg;
        root_res_next      = root_res_reg;
        root_bit_next      = root_bit_reg;
        heat_next          = heat_reg;

        // output word taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // configuration writes
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_CHANNEL_COUNT: channel_count_next = cfg_data[1:0];
                REG_ENERGY_FLOOR:  energy_floor_next  = cfg_data;
                default:           ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_word;
                    step_next  = 3'd0;
                    state_next = ST_MIX;
                end
            end
            ST_MIX:
            begin
                step_next = step_reg + 3'd1;
                case (step_reg)
                    3'd1: t_next  = $signed(prod_reg[41:0]);
                    3'd2: ol_next = mix_res;
                    3'd3: t_next  = $signed(prod_reg[41:0]);
                    3'd4: or_next = channel_count_reg[1] ? mix_res : '0;
                    3'd5: sum_in_next  = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
                    3'd6: sum_out_next = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
                    3'd7:
                    begin
                        if (cross_sum[ACC_W] != cross_sum[ACC_W-1])
                        begin
                            sum_cross_next = cross_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                                              : {1'b0, {(ACC_W-1){1'b1}}};
                        end
                        else
                        begin
                            sum_cross_next = cross_sum[ACC_W-1:0];
                        end
                        heat_next  = '0;
                        state_next = item_reg.block_end ? ST_CHECK : ST_FINISH;
                    end
                    default: ;
                endcase
            end
            ST_CHECK:
            begin
                if ((sum_in_reg <= {20'b0, energy_floor_reg}) ||
                    (sum_out_reg <= {20'b0, energy_floor_reg}))
                begin
                    heat_next  = '0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    step_next  = 3'd0;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                step_next = step_reg + 3'd1;
                case (step_reg)
                    3'd1: num_next = {60'b0, prod_reg[59:0]};
                    3'd2: num_next = num_reg + {29'b0, prod_reg[59:0], 31'b0};
                    3'd3:
                    begin
                        num_next   = num_reg + {prod_reg[59:0], 60'b0};
                        step_next  = 3'd0;
                        iter_next  = DIV1_STEPS;
                        rem_next   = '0;
                        quo_next   = '0;
                        over_next  = 1'b0;
                        state_next = ST_DIV1;
                    end
                    default: ;
                endcase
            end
            ST_DIV1, ST_DIV2:
            begin
                rem_next  = div_ge ? div_diff[ACC_W-1:0] : rem_sh[ACC_W-1:0];
                quo_next  = quo_shift;
                over_next = over_reg | quo_reg[ACC_W-1];
                num_next  = {num_reg[118:0], 1'b0};
                iter_next = iter_reg - 7'd1;
                if (iter_reg == 7'd1)
                begin
                    if (state_reg == ST_DIV1)
                    begin
                        state_next = ST_RESID;
                    end
                    else
                    begin
                        root_n_next   = root_n_clamp;
                        root_res_next = '0;
                        root_bit_next = ROOT_BIT_INIT;
                        state_next    = ST_ROOT;
                    end
                end
            end
            ST_RESID:
            begin
                num_next   = {residual, 60'b0};
                iter_next  = DIV2_STEPS;
                rem_next   = '0;
                quo_next   = '0;
                over_next  = 1'b0;
                state_next = ST_DIV2;
            end
            ST_ROOT:
            begin
                root_n_next   = root_ge ? (root_n_reg - root_sum[32:0]) : root_n_reg;
                root_res_next = root_res_upd;
                root_bit_next = root_bit_reg >> 2;
                if (root_bit_reg[0])
                begin
                    heat_next  = (root_res_upd > {16'b0, HEAT_ONE}) ? HEAT_ONE
                                                                    : root_res_upd[HEAT_W-1:0];
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_word_next.out_left   = ol_reg;
                    out_word_next.out_right  = or_reg;
                    out_word_next.heat       = heat_reg;
                    out_word_next.heat_valid = item_reg.block_end;
                    out_valid_next           = 1'b1;
                    if (item_reg.block_end)
                    begin
                        sum_in_next    = '0;
                        sum_out_next   = '0;
                        sum_cross_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state, output valid, configuration and accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            step_reg          <= '0;
            iter_reg          <= '0;
            out_valid_reg     <= 1'b0;
            channel_count_reg <= CHANNEL_COUNT_RST;
            energy_floor_reg  <= ENERGY_FLOOR_RST;
            sum_in_reg        <= '0;
            sum_out_reg       <= '0;
            sum_cross_reg     <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            step_reg          <= step_next;
            iter_reg          <= iter_next;
            out_valid_reg     <= out_valid_next;
            channel_count_reg <= channel_count_next;
            energy_floor_reg  <= energy_floor_next;
            sum_in_reg        <= sum_in_next;
            sum_out_reg       <= sum_out_next;
            sum_cross_reg     <= sum_cross_next;
        end
    end

    // datapath registers and the shared multiplier
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        out_word_reg <= out_word_next;
        prod_reg     <= mul_a * mul_b;
        t_reg        <= t_next;
        ol_reg       <= ol_next;
        or_reg       <= or_next;
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        over_reg     <= over_next;
        root_n_reg   <= root_n_next;
        root_res_reg <= root_res_next;
        root_bit_reg <= root_bit_next;
        heat_reg     <= heat_next;
    end

endmodule

@@ hdl/dwm_checker.sv @@
// port-level assertions for the mixer and meter, bound to the top level
`timescale 1ns / 1ps
`include "dry_wet_mix_distortion_meter_top_macros.svh"

module dwm_checker
    import dwm_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input dwm_in_word_t         in_word,
    input logic                 out_valid,
    input logic                 out_stall,
    input dwm_out_word_t        out_word,
    input logic                 cfg_wr_en,
    input logic [CFG_IDX_W-1:0] cfg_index,
    input logic [FLOOR_W-1:0]   cfg_data
);

    // an accepted word keeps the input side stalled while it is worked on
    `DWM_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "input not stalled after accept")

    // a stalled result word holds
    `DWM_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_word), "stalled output word changed")

    // heat only on block-end words
    `DWM_ASSERT_IMP(a_heat_zero, clk, rst_n, out_valid && !out_word.heat_valid, out_word.heat == '0, "heat nonzero off block end")

    // heat never above unity
    `DWM_ASSERT_IMP(a_heat_range, clk, rst_n, out_valid, out_word.heat <= HEAT_ONE, "heat above unity")

endmodule

bind dry_wet_mix_distortion_meter_top dwm_checker u_dwm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
);
